### rtl/ilte_pkg.sv
// Shared types and constants for the indexed list table engine.
// Used by ilte_ctrl, ilte_dp and the top level; no dependencies.
package ilte_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = (CW > 8) ? CW : 8;

  typedef enum logic [3:0] {
    OP_INSERT  = 4'd0,
    OP_APPEND  = 4'd1,
    OP_PREPEND = 4'd2,
    OP_DELETE  = 4'd3,
    OP_ROTATE  = 4'd4,
    OP_REVERSE = 4'd5,
    OP_MIDDLE  = 4'd6,
    OP_SEARCH  = 4'd7,
    OP_DUMP    = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BOUNDS = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_MISS   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DSEL_ZERO = 2'd0,
    DSEL_RD   = 2'd1,
    DSEL_ONES = 2'd2
  } dsel_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_INS_INIT,
    DP_RD_AM1,
    DP_WR_A_RD_DEC,
    DP_INS_FIN,
    DP_A_POS,
    DP_RD_AP1,
    DP_WR_A_RD_INC,
    DP_CNT_DEC,
    DP_MOD_INIT,
    DP_MOD_STEP,
    DP_REV_ALL,
    DP_REV_HEAD,
    DP_REV_TAIL,
    DP_RD_A,
    DP_TMP_RD_BM1,
    DP_WR_A_RD,
    DP_WR_BM1_TMP,
    DP_RD_MID,
    DP_A_ZERO,
    DP_A_INC,
    DP_EMIT
  } dp_op_t;

  // Description of one result transaction
  typedef struct packed {
    dsel_t   dsel;
    logic    pos_a;
    status_t status;
    logic    last;
    logic    more;
  } em_t;

  typedef struct packed {
    dp_op_t op;
    em_t    em;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] opc;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       full;
    logic       cnt_zero;
    logic       a_gt_pos;
    logic       a1_lt_cnt;
    logic       a1_lt_b;
    logic       a_lt_cnt;
    logic       a_last;
    logic       rd_eq_val;
    logic       mod_done;
    logic       k_zero;
    logic       out_free;
  } dp_stat_t;

  localparam em_t EM_OK     = '{DSEL_ZERO, 1'b0, ST_OK,     1'b1, 1'b0};
  localparam em_t EM_BOUNDS = '{DSEL_ZERO, 1'b0, ST_BOUNDS, 1'b1, 1'b0};
  localparam em_t EM_FULL   = '{DSEL_ZERO, 1'b0, ST_FULL,   1'b1, 1'b0};
  localparam em_t EM_EMPTY  = '{DSEL_ONES, 1'b0, ST_EMPTY,  1'b1, 1'b0};
  localparam em_t EM_MISS   = '{DSEL_ZERO, 1'b0, ST_MISS,   1'b1, 1'b0};

endpackage

### rtl/ilte_dp.sv
// Datapath: entry memory, count, address counters, modulo unit, result register.
// Depends on ilte_pkg; driven by ilte_ctrl through dp_cmd_t.
module ilte_dp import ilte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [3:0]         opcode,
  input  logic [7:0]         position_in,
  input  logic signed [31:0] data_in,
  input  logic [15:0]        rotate_by,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] data_out,
  output logic [4:0]         found_position,
  output logic [2:0]         status,
  output logic [5:0]         count_out,
  output logic               is_empty,
  output logic               last_result
);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [31:0]   val;
  logic [31:0]   tmp;
  logic [3:0]    opc;
  logic [PW-1:0] pos;
  logic [15:0]   rot_sh;
  logic [CW-1:0] cnt;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] rem;
  logic [4:0]    mcnt;

  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW:0]   rem_sh;
  logic [CW-1:0] rem_next;
  logic [CW:0]   a_p1;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] a_ext;
  logic [PW-1:0] pos_load;

  assign a_p1    = {1'b0, a} + {{CW{1'b0}}, 1'b1};
  assign cnt_ext = PW'(cnt);
  assign a_ext   = PW'(a);

  // one restoring step of rot mod cnt
  assign rem_sh   = {rem, rot_sh[15]};
  assign rem_next = (rem_sh >= {1'b0, cnt}) ? CW'(rem_sh - {1'b0, cnt}) : CW'(rem_sh);

  always_comb begin
    case (opcode)
      OP_APPEND:  pos_load = cnt_ext;
      OP_PREPEND: pos_load = '0;
      default:    pos_load = PW'(position_in);
    endcase
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = a;
    case (cmd.op)
      DP_RD_AM1:     rd_addr = a - 1'b1;
      DP_RD_AP1:     rd_addr = a_p1[CW-1:0];
      DP_RD_A:       rd_addr = a;
      DP_TMP_RD_BM1: rd_addr = b - 1'b1;
      DP_RD_MID:     rd_addr = cnt >> 1;
      default:       rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = a;
    wr_data = rd_data;
    case (cmd.op)
      DP_WR_A_RD_DEC,
      DP_WR_A_RD_INC,
      DP_WR_A_RD: begin
        wr_addr = a;
        wr_data = rd_data;
      end
      DP_INS_FIN: begin
        wr_addr = pos[CW-1:0];
        wr_data = val;
      end
      DP_WR_BM1_TMP: begin
        wr_addr = b - 1'b1;
        wr_data = tmp;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr[AW-1:0]];
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        opc    <= opcode;
        pos    <= pos_load;
        val    <= data_in;
        rot_sh <= rotate_by;
      end
      DP_INS_INIT:    a <= cnt;
      DP_WR_A_RD_DEC: a <= a - 1'b1;
      DP_A_POS:       a <= pos[CW-1:0];
      DP_WR_A_RD_INC: a <= a_p1[CW-1:0];
      DP_MOD_INIT: begin
        rem  <= '0;
        mcnt <= '0;
      end
      DP_MOD_STEP: begin
        rem    <= rem_next;
        rot_sh <= {rot_sh[14:0], 1'b0};
        mcnt   <= mcnt + 5'd1;
      end
      DP_REV_ALL: begin
        a <= '0;
        b <= cnt;
      end
      DP_REV_HEAD: begin
        a <= '0;
        b <= rem;
      end
      DP_REV_TAIL: begin
        a <= rem;
        b <= cnt;
      end
      DP_TMP_RD_BM1: tmp <= rd_data;
      DP_WR_BM1_TMP: begin
        a <= a_p1[CW-1:0];
        b <= b - 1'b1;
      end
      DP_A_ZERO: a <= '0;
      DP_A_INC:  a <= a_p1[CW-1:0];
      DP_EMIT: begin
        case (cmd.em.dsel)
          DSEL_RD:   data_out <= rd_data;
          DSEL_ONES: data_out <= '1;
          default:   data_out <= '0;
        endcase
        found_position <= cmd.em.pos_a ? 5'(a) : 5'd0;
        status         <= cmd.em.status;
        count_out      <= 6'(cnt);
        is_empty       <= (cnt == '0);
        last_result    <= cmd.em.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        DP_INS_FIN: cnt <= cnt + 1'b1;
        DP_CNT_DEC: cnt <= cnt - 1'b1;
        default: ;
      endcase
      if (cmd.op == DP_EMIT) out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.opc        = opc;
    stat.pos_gt_cnt = pos > cnt_ext;
    stat.pos_ge_cnt = pos >= cnt_ext;
    stat.full       = (cnt >= CW'(DEPTH));
    stat.cnt_zero   = (cnt == '0);
    stat.a_gt_pos   = a_ext > pos;
    stat.a1_lt_cnt  = a_p1 < {1'b0, cnt};
    stat.a1_lt_b    = a_p1 < {1'b0, b};
    stat.a_lt_cnt   = a < cnt;
    stat.a_last     = a_p1 == {1'b0, cnt};
    stat.rd_eq_val  = rd_data == val;
    stat.mod_done   = mcnt[4];
    stat.k_zero     = (rem == '0);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

### rtl/ilte_ctrl.sv
// Command sequencer: decodes one transaction and steps the datapath.
// Depends on ilte_pkg; drives ilte_dp through dp_cmd_t.
module ilte_ctrl import ilte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INS_CHK, S_INS_WR, S_DEL_CHK, S_DEL_WR, S_MOD,
    S_REV_CHK, S_REV_R2, S_REV_W1, S_REV_W2, S_SRC_CHK, S_SRC_CMP,
    S_DMP_RD, S_DMP_NEXT, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_ALL, PH_HEAD, PH_LAST
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  em_t    em, em_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    em_next    = em;
    cmd.op     = DP_NOP;
    cmd.em     = em;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_EMIT;
        em_next    = EM_OK;
        case (stat.opc)
          OP_INSERT, OP_APPEND, OP_PREPEND: begin
            if (stat.pos_gt_cnt) em_next = EM_BOUNDS;
            else if (stat.full)  em_next = EM_FULL;
            else begin
              cmd.op     = DP_INS_INIT;
              state_next = S_INS_CHK;
            end
          end
          OP_DELETE: begin
            if (stat.pos_ge_cnt) em_next = EM_BOUNDS;
            else begin
              cmd.op     = DP_A_POS;
              state_next = S_DEL_CHK;
            end
          end
          OP_ROTATE: begin
            if (!stat.cnt_zero) begin
              cmd.op     = DP_MOD_INIT;
              state_next = S_MOD;
            end
          end
          OP_REVERSE: begin
            if (!stat.cnt_zero) begin
              cmd.op     = DP_REV_ALL;
              phase_next = PH_LAST;
              state_next = S_REV_CHK;
            end
          end
          OP_MIDDLE: begin
            if (stat.cnt_zero) em_next = EM_EMPTY;
            else begin
              cmd.op  = DP_RD_MID;
              em_next = '{DSEL_RD, 1'b0, ST_OK, 1'b1, 1'b0};
            end
          end
          OP_SEARCH: begin
            cmd.op     = DP_A_ZERO;
            state_next = S_SRC_CHK;
          end
          OP_DUMP: begin
            if (stat.cnt_zero) em_next = EM_EMPTY;
            else begin
              cmd.op     = DP_A_ZERO;
              state_next = S_DMP_RD;
            end
          end
          default: ;
        endcase
      end
      S_INS_CHK: begin
        if (stat.a_gt_pos) begin
          cmd.op     = DP_RD_AM1;
          state_next = S_INS_WR;
        end else begin
          cmd.op     = DP_INS_FIN;
          em_next    = EM_OK;
          state_next = S_EMIT;
        end
      end
      S_INS_WR: begin
        cmd.op     = DP_WR_A_RD_DEC;
        state_next = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (stat.a1_lt_cnt) begin
          cmd.op     = DP_RD_AP1;
          state_next = S_DEL_WR;
        end else begin
          cmd.op     = DP_CNT_DEC;
          em_next    = EM_OK;
          state_next = S_EMIT;
        end
      end
      S_DEL_WR: begin
        cmd.op     = DP_WR_A_RD_INC;
        state_next = S_DEL_CHK;
      end
      // right rotate by k = reverse all, then first k, then the rest
      S_MOD: begin
        if (!stat.mod_done) cmd.op = DP_MOD_STEP;
        else if (stat.k_zero) begin
          em_next    = EM_OK;
          state_next = S_EMIT;
        end else begin
          cmd.op     = DP_REV_ALL;
          phase_next = PH_ALL;
          state_next = S_REV_CHK;
        end
      end
      S_REV_CHK: begin
        if (stat.a1_lt_b) begin
          cmd.op     = DP_RD_A;
          state_next = S_REV_R2;
        end else begin
          case (phase)
            PH_ALL: begin
              cmd.op     = DP_REV_HEAD;
              phase_next = PH_HEAD;
            end
            PH_HEAD: begin
              cmd.op     = DP_REV_TAIL;
              phase_next = PH_LAST;
            end
            default: begin
              em_next    = EM_OK;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_REV_R2: begin
        cmd.op     = DP_TMP_RD_BM1;
        state_next = S_REV_W1;
      end
      S_REV_W1: begin
        cmd.op     = DP_WR_A_RD;
        state_next = S_REV_W2;
      end
      S_REV_W2: begin
        cmd.op     = DP_WR_BM1_TMP;
        state_next = S_REV_CHK;
      end
      S_SRC_CHK: begin
        if (stat.a_lt_cnt) begin
          cmd.op     = DP_RD_A;
          state_next = S_SRC_CMP;
        end else begin
          em_next    = EM_MISS;
          state_next = S_EMIT;
        end
      end
      S_SRC_CMP: begin
        if (stat.rd_eq_val) begin
          em_next    = '{DSEL_ZERO, 1'b1, ST_OK, 1'b1, 1'b0};
          state_next = S_EMIT;
        end else begin
          cmd.op     = DP_A_INC;
          state_next = S_SRC_CHK;
        end
      end
      S_DMP_RD: begin
        cmd.op     = DP_RD_A;
        em_next    = '{DSEL_RD, 1'b1, ST_OK, stat.a_last, !stat.a_last};
        state_next = S_EMIT;
      end
      S_DMP_NEXT: begin
        cmd.op     = DP_A_INC;
        state_next = S_DMP_RD;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = DP_EMIT;
          state_next = em.more ? S_DMP_NEXT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_LAST;
      em    <= EM_OK;
    end else begin
      state <= state_next;
      phase <= phase_next;
      em    <= em_next;
    end
  end

endmodule

### rtl/indexed_list_table_engine_unit.sv
// Indexed list table engine: one command transaction at a time, accepted in S_IDLE, then decoded.
// Insert/delete shift one entry at a time, a read then a write; reverse swaps each pair by
// two reads and two writes; rotate runs a restoring modulo unit, then, unless k is zero, three reversals.
// Search reads and compares one entry at a time; dump gives one result per entry, each held until taken.
// Rate is set by the single-port entry memory. Reset clears the count and the result
// valid flag; entries are not cleared and read only below the count.
module indexed_list_table_engine_unit import ilte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic [7:0]         position_in,
  input  logic signed [31:0] data_in,
  input  logic [15:0]        rotate_by,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] data_out,
  output logic [4:0]         found_position,
  output logic [2:0]         status,
  output logic [5:0]         count_out,
  output logic               is_empty,
  output logic               last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilte_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .position_in    (position_in),
    .data_in        (data_in),
    .rotate_by      (rotate_by),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_out       (data_out),
    .found_position (found_position),
    .status         (status),
    .count_out      (count_out),
    .is_empty       (is_empty),
    .last_result    (last_result)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transaction accepted while one is in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count_out == 6'd0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_out <= 6'(DEPTH)))
    else $error("count beyond table depth");

endmodule

### test/ilte_list_checker.sv
// Checker for the indexed list table engine: watches both channels, keeps its own
// copy of the list, predicts every result transaction and compares. Depends on ilte_pkg.
module ilte_list_checker import ilte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         opcode,
  input  logic [7:0]         position_in,
  input  logic signed [31:0] data_in,
  input  logic [15:0]        rotate_by,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] data_out,
  input  logic [4:0]         found_position,
  input  logic [2:0]         status,
  input  logic [5:0]         count_out,
  input  logic               is_empty,
  input  logic               last_result,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] data;
    logic [4:0]  fpos;
    status_t     st;
    logic [5:0]  cnt;
    logic        empty;
    logic        last;
  } list_result_t;

  logic [31:0]  words [DEPTH];
  int           held;
  list_result_t expected_q[$];

  function automatic list_result_t mk(logic [31:0] d, int p, status_t s, logic l);
    list_result_t r;
    r.data = d; r.fpos = p[4:0]; r.st = s;
    r.cnt = held[5:0]; r.empty = (held == 0); r.last = l;
    return r;
  endfunction

  task automatic apply_command(logic [3:0] op, int p, logic [31:0] v, int rot);
    logic [31:0] snap [DEPTH];
    status_t s;
    int k;
    int n;
    bit hit;
    s = ST_OK;
    case (op)
      OP_INSERT, OP_PREPEND, OP_APPEND: begin
        if (op == OP_PREPEND) p = 0;
        if (op == OP_APPEND) p = held;
        if (p > held) s = ST_BOUNDS;
        else if (held >= DEPTH) s = ST_FULL;
        else begin
          for (int i = held; i > p; i--) words[i] = words[i-1];
          words[p] = v;
          held++;
        end
        expected_q.push_back(mk('0, 0, s, 1'b1));
      end
      OP_DELETE: begin
        if (p >= held) s = ST_BOUNDS;
        else begin
          for (int i = p; i + 1 < held; i++) words[i] = words[i+1];
          held--;
        end
        expected_q.push_back(mk('0, 0, s, 1'b1));
      end
      OP_ROTATE: begin
        if (held != 0) begin
          k = rot % held;
          snap = words;
          for (int i = 0; i < held; i++) words[(i + k) % held] = snap[i];
        end
        expected_q.push_back(mk('0, 0, ST_OK, 1'b1));
      end
      OP_REVERSE: begin
        snap = words;
        for (int i = 0; i < held; i++) words[i] = snap[held-1-i];
        expected_q.push_back(mk('0, 0, ST_OK, 1'b1));
      end
      OP_MIDDLE: begin
        if (held == 0) expected_q.push_back(mk('1, 0, ST_EMPTY, 1'b1));
        else expected_q.push_back(mk(words[held/2], 0, ST_OK, 1'b1));
      end
      OP_SEARCH: begin
        hit = 0;
        for (int i = 0; i < held && !hit; i++)
          if (words[i] == v) begin
            hit = 1;
            expected_q.push_back(mk('0, i, ST_OK, 1'b1));
          end
        if (!hit) expected_q.push_back(mk('0, 0, ST_MISS, 1'b1));
      end
      OP_DUMP: begin
        n = held;
        if (n == 0) expected_q.push_back(mk('1, 0, ST_EMPTY, 1'b1));
        for (int i = 0; i < n; i++)
          expected_q.push_back(mk(words[i], i, ST_OK, i + 1 == n));
      end
      default: expected_q.push_back(mk('0, 0, ST_OK, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      held = 0;
      mismatches <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready)
        apply_command(opcode, position_in, data_in, rotate_by);
      if (out_valid && out_ready) begin
        got = '{data_out, found_position, status_t'(status), count_out, is_empty,
                last_result};
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### test/indexed_list_table_engine_unit_tb.sv
// Stimulus and verdict for the indexed list table engine: directed commands, then
// random list traffic under varying idle/stall phases. Needs ilte_pkg and ilte_list_checker.
module indexed_list_table_engine_unit_tb;
  import ilte_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [3:0]         opcode = 0;
  logic [7:0]         position_in = 0;
  logic signed [31:0] data_in = 0;
  logic [15:0]        rotate_by = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] data_out;
  logic [4:0]         found_position;
  logic [2:0]         status;
  logic [5:0]         count_out;
  logic               is_empty;
  logic               last_result;
  int                 mismatches;
  int                 pending;
  int                 send_idle = 0;
  int                 recv_stall = 0;
  int                 quiet = 0;
  int                 list_len = 0;
  logic [31:0]        recent [8];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  indexed_list_table_engine_unit u_dut (.*);

  ilte_list_checker u_chk (.*);

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up after acceptance; the next send or drain replaces or drops it
  task automatic send(logic [3:0] op, logic [7:0] p, logic [31:0] v, logic [15:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    opcode <= op; position_in <= p; data_in <= v; rotate_by <= r;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // track length for picking sensible positions
    case (op)
      OP_INSERT: if (p <= list_len && list_len < DEPTH) list_len++;
      OP_APPEND, OP_PREPEND: if (list_len < DEPTH) list_len++;
      OP_DELETE: if (p < list_len) list_len--;
      default: ;
    endcase
    if (op <= OP_PREPEND) recent[$urandom_range(7)] = v;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_command();
    int sel;
    logic [3:0] op;
    logic [7:0] p;
    logic [31:0] v;
    sel = $urandom_range(99);
    v = $urandom;
    if ($urandom_range(3) == 0) v = recent[$urandom_range(7)];
    p = (list_len == 0) ? 8'd0 : 8'($urandom_range(list_len));
    if ($urandom_range(9) == 0) p = 8'($urandom);
    if (sel < 18) op = OP_INSERT;
    else if (sel < 30) op = OP_APPEND;
    else if (sel < 38) op = OP_PREPEND;
    else if (sel < 56) op = OP_DELETE;
    else if (sel < 64) op = OP_ROTATE;
    else if (sel < 70) op = OP_REVERSE;
    else if (sel < 78) op = OP_MIDDLE;
    else if (sel < 90) op = OP_SEARCH;
    else if (sel < 97) op = OP_DUMP;
    else op = 4'($urandom_range(15, 9));
    send(op, p, v, 16'($urandom));
  endtask

  initial begin
    foreach (recent[i]) recent[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // empty-list corner cases, then short-list and unknown-opcode cases
    send(OP_MIDDLE, 0, 0, 0);
    send(OP_DUMP, 0, 0, 0);
    send(OP_SEARCH, 0, 5, 0);
    send(OP_DELETE, 0, 0, 0);
    send(OP_ROTATE, 0, 0, 16'hffff);
    send(OP_REVERSE, 0, 0, 0);
    send(OP_INSERT, 1, 7, 0);
    send(OP_INSERT, 0, 32'h8000_0000, 0);
    send(OP_APPEND, 0, 32'h7fff_ffff, 0);
    send(OP_PREPEND, 8'hff, 32'hffff_ffff, 0);
    send(OP_SEARCH, 0, 32'h7fff_ffff, 0);
    send(OP_ROTATE, 0, 0, 16'hffff);
    send(OP_REVERSE, 0, 0, 0);
    send(OP_DELETE, 8'hff, 0, 0);
    send(4'hf, 8'hff, 32'hffff_ffff, 16'hffff);
    // fill past capacity
    while (list_len < DEPTH) send(OP_APPEND, 0, $urandom, 0);
    send(OP_APPEND, 0, 1, 0);
    send(OP_PREPEND, 0, 2, 0);
    send(OP_INSERT, 5, 3, 0);
    send(OP_INSERT, 33, 3, 0);
    send(OP_DUMP, 0, 0, 0);
    send(OP_MIDDLE, 0, 0, 0);
    send(OP_DELETE, 31, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 56; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 56; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      for (int n = 0; n < 70; n++) begin
        if (list_len > 20 && $urandom_range(2) == 0) send(OP_DELETE, 0, 0, 0);
        else random_command();
      end
      drain();
    end
    recv_stall = 0;
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
